// ----- src/mlbdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlbdb_pkg
// Types and constants of the multi-lane byte delay bank.
// ----------------------------------------------------------------------------
package mlbdb_pkg;

  localparam int unsigned Lanes        = 32;
  localparam int unsigned LaneBits     = $clog2(Lanes);
  localparam int unsigned LaneCntBits  = 6;
  localparam int unsigned LaneCntReset = 28;
  localparam int unsigned DelayBits    = 7;
  localparam int unsigned StoreDepth   = 4096;
  localparam int unsigned AddrBits     = $clog2(StoreDepth);
  localparam int unsigned LaneSlots    = StoreDepth / Lanes;
  localparam int unsigned SlotBits     = $clog2(LaneSlots);
  localparam int unsigned FramesBits   = 8;
  localparam int unsigned FramesSat    = 128;
  localparam int unsigned DelayRegs    = 4;
  localparam int unsigned DelaysPerReg = 8;
  localparam int unsigned DelayRegBits = DelayBits * DelaysPerReg;
  localparam int unsigned GroupSize    = 4;
  localparam int unsigned Groups       = Lanes / GroupSize;
  localparam int unsigned DataBits     = 64;
  localparam int unsigned PaddrBits    = 6;
  localparam int unsigned RegIdxBits   = 3;
  localparam int unsigned SettleCycles = 2;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [RegIdxBits-1:0] {
    REG_LANE_COUNT = 3'd0,
    REG_DELAYS_0   = 3'd1,
    REG_DELAYS_1   = 3'd2,
    REG_DELAYS_2   = 3'd3,
    REG_DELAYS_3   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          byte_out;
    logic [LaneBits-1:0] lane;
    logic                last_of_frame;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/multi_lane_byte_delay_bank.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_lane_byte_delay_bank
// Per-lane frame delay of a byte stream held in one shared ring memory.
// ----------------------------------------------------------------------------
// Usage:
//   Send one item per byte on the input channel, in lane order; the block
//   tracks the lane itself and wraps at lane_count. A flush item restarts
//   the frame count and all ring pointers and gives no result.
//   Each push on a lane with a nonzero delay reads and writes one entry of a
//   4096 x 8 single-port memory (read-first); one item is accepted every cycle
//   unless the input stalls. A result passes through the memory stage and the
//   output register once the frame count exceeds the longest active delay;
//   before that a push gives none. Configuration goes through the APB port,
//   one 64-bit register at each 8-byte address. After a register write the
//   longest-delay search runs through a two-stage registered tree and the
//   input stalls while it settles. Reset clears the lane position, frame count,
//   pointers and delays, sets lane_count to 28 and stalls the input until the
//   search settles; the memory is not cleared and needs no clearing pass.
//   When the receiver stalls, the output register holds its item, one
//   more item enters the memory stage, and then the input stalls.
// ----------------------------------------------------------------------------
module multi_lane_byte_delay_bank (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire mlbdb_pkg::in_item_t           in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mlbdb_pkg::out_item_t               out_item_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mlbdb_pkg::PaddrBits-1:0] paddr,
  input  wire logic [mlbdb_pkg::DataBits-1:0]  pwdata,
  output logic [mlbdb_pkg::DataBits-1:0]     prdata,
  output logic                               pready
);
  import mlbdb_pkg::*;

  logic [LaneCntBits-1:0]  lane_count_q;
  logic [DelayRegBits-1:0] delay_q [DelayRegs];
  logic [DelayBits-1:0]    lane_delay [Lanes];
  logic                    cfg_wr;
  reg_idx_e                cfg_idx;
  logic [1:0]              settle_q;

  logic [LaneCntBits-1:0]  n_act;
  logic [DelayBits-1:0]    grp_max_d [Groups];
  logic [DelayBits-1:0]    grp_max_q [Groups];
  logic [DelayBits-1:0]    maxd_d, maxd_q;

  logic [SlotBits-1:0]     ptr_q [Lanes];
  logic [LaneBits-1:0]     lane_pos_q;
  logic [FramesBits-1:0]   frames_q;

  logic                    in_acc, push, flush;
  logic [LaneBits-1:0]     pos;
  logic [LaneCntBits-1:0]  pos_inc;
  logic [FramesBits-1:0]   frames_d;
  logic [DelayBits-1:0]    cur_delay;
  logic [SlotBits-1:0]     cur_ptr;
  logic [SlotBits:0]       ptr_inc;
  logic                    mem_en, emit;
  logic [AddrBits-1:0]     mem_addr;

  logic [7:0]              ring_mem [StoreDepth];
  logic [7:0]              mem_rdata_q;

  logic                    s1_valid_q, s1_bypass_q, s1_move;
  logic [7:0]              s1_byte_q;
  logic [LaneBits-1:0]     s1_lane_q;
  logic                    s1_last_q;
  logic                    out_valid_q;
  out_item_t               out_item_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PaddrBits-1 -: RegIdxBits]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_LANE_COUNT: prdata = DataBits'(lane_count_q);
      REG_DELAYS_0:   prdata = DataBits'(delay_q[0]);
      REG_DELAYS_1:   prdata = DataBits'(delay_q[1]);
      REG_DELAYS_2:   prdata = DataBits'(delay_q[2]);
      REG_DELAYS_3:   prdata = DataBits'(delay_q[3]);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_count_q <= LaneCntBits'(LaneCntReset);
      for (int r = 0; r < DelayRegs; r++) delay_q[r] <= '0;
      settle_q <= 2'(SettleCycles);
    end else begin
      if (cfg_wr) begin
        settle_q <= 2'(SettleCycles);
        unique case (cfg_idx)
          REG_LANE_COUNT: lane_count_q <= pwdata[LaneCntBits-1:0];
          REG_DELAYS_0:   delay_q[0]   <= pwdata[DelayRegBits-1:0];
          REG_DELAYS_1:   delay_q[1]   <= pwdata[DelayRegBits-1:0];
          REG_DELAYS_2:   delay_q[2]   <= pwdata[DelayRegBits-1:0];
          REG_DELAYS_3:   delay_q[3]   <= pwdata[DelayRegBits-1:0];
          default: ;
        endcase
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  // per-lane delays and active lane count
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      lane_delay[l] = delay_q[l / DelaysPerReg][(l % DelaysPerReg) * DelayBits +: DelayBits];
    end
  end

  always_comb begin
    if (lane_count_q == '0) begin
      n_act = LaneCntBits'(1);
    end else if (lane_count_q > LaneCntBits'(Lanes)) begin
      n_act = LaneCntBits'(Lanes);
    end else begin
      n_act = lane_count_q;
    end
  end

  // longest active delay, two registered levels
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_max_d[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        if ((LaneCntBits'(g * GroupSize + k) < n_act) &&
            (lane_delay[g * GroupSize + k] > grp_max_d[g])) begin
          grp_max_d[g] = lane_delay[g * GroupSize + k];
        end
      end
    end
    maxd_d = '0;
    for (int g = 0; g < Groups; g++) begin
      if (grp_max_q[g] > maxd_d) maxd_d = grp_max_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < Groups; g++) grp_max_q[g] <= '0;
      maxd_q <= '0;
    end else begin
      for (int g = 0; g < Groups; g++) grp_max_q[g] <= grp_max_d[g];
      maxd_q <= maxd_d;
    end
  end

  // accept stage
  assign s1_move    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (settle_q != 2'd0) | (s1_valid_q & ~s1_move);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign flush      = in_acc & (in_item_i.command == CMD_FLUSH);
  assign push       = in_acc & (in_item_i.command == CMD_PUSH);

  always_comb begin
    pos = lane_pos_q;
    if (LaneCntBits'(lane_pos_q) >= n_act) pos = '0;
    pos_inc   = LaneCntBits'(pos) + LaneCntBits'(1);
    frames_d  = frames_q;
    if ((pos == '0) && (frames_q < FramesBits'(FramesSat))) frames_d = frames_q + 1'b1;
    cur_delay = lane_delay[pos];
    cur_ptr   = ptr_q[pos];
    ptr_inc   = {1'b0, cur_ptr} + (SlotBits+1)'(1);
    mem_addr  = {pos, cur_ptr};
    mem_en    = push & (cur_delay != '0);
    emit      = frames_d > FramesBits'(maxd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < Lanes; l++) ptr_q[l] <= '0;
      lane_pos_q <= '0;
      frames_q   <= '0;
    end else if (flush) begin
      for (int l = 0; l < Lanes; l++) ptr_q[l] <= '0;
      lane_pos_q <= '0;
      frames_q   <= '0;
    end else if (push) begin
      frames_q   <= frames_d;
      lane_pos_q <= (pos_inc >= n_act) ? '0 : pos_inc[LaneBits-1:0];
      if (cur_delay != '0) begin
        ptr_q[pos] <= (ptr_inc >= (SlotBits+1)'(cur_delay)) ? '0 : ptr_inc[SlotBits-1:0];
      end
    end
  end

  // ring memory, read-first
  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      mem_rdata_q        <= ring_mem[mem_addr];
      ring_mem[mem_addr] <= in_item_i.byte_in;
    end
  end

  // memory stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (push) begin
      s1_valid_q <= emit;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      s1_bypass_q <= (cur_delay == '0);
      s1_byte_q   <= in_item_i.byte_in;
      s1_lane_q   <= pos;
      s1_last_q   <= (pos_inc == n_act);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_item_q.byte_out      <= s1_bypass_q ? s1_byte_q : mem_rdata_q;
      out_item_q.lane          <= s1_lane_q;
      out_item_q.last_of_frame <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- tb/multi_lane_byte_delay_bank_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_lane_byte_delay_bank_checker
// Watches the input, output and register ports of the delay bank. It keeps
// its own copy of the lane rings, pointers, lane position and frame count,
// predicts the delayed byte of every accepted push, and compares each
// accepted output item, field by field, with the oldest byte still due.
// ----------------------------------------------------------------------------
module multi_lane_byte_delay_bank_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  mlbdb_pkg::in_item_t             in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  mlbdb_pkg::out_item_t            out_item_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mlbdb_pkg::PaddrBits-1:0] paddr,
  input  logic [mlbdb_pkg::DataBits-1:0]  pwdata,
  input  logic                            pready,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);
  import mlbdb_pkg::*;

  logic [LaneCntBits-1:0]  lane_cnt_q;
  logic [DelayRegBits-1:0] delay_q [DelayRegs];
  logic [7:0]              ring_mem [StoreDepth];
  logic [DelayBits-1:0]    ptr_q [Lanes];
  int unsigned             pos_q;
  int unsigned             frames_q;
  out_item_t               delayed_bytes_due [$];
  out_item_t               want;

  function automatic int unsigned lanes_active();
    if (lane_cnt_q == 0) return 1;
    if (lane_cnt_q > Lanes) return Lanes;
    return 32'(lane_cnt_q);
  endfunction

  function automatic int unsigned delay_of(input int unsigned lane);
    logic [DelayRegBits-1:0] r;
    r = delay_q[lane / DelaysPerReg];
    return 32'(r[DelayBits*(lane % DelaysPerReg) +: DelayBits]);
  endfunction

  task automatic run_delay_bank(input in_item_t item);
    int unsigned n, lane, d, maxd, slot, nxt;
    logic [7:0]  data;
    out_item_t   r;
    n = lanes_active();
    if (item.command == CMD_FLUSH) begin
      frames_q = 0;
      pos_q = 0;
      foreach (ptr_q[k]) ptr_q[k] = '0;
    end else begin
      lane = (pos_q >= n) ? 0 : pos_q;
      if (lane == 0 && frames_q < FramesSat) frames_q++;
      d = delay_of(lane);
      data = item.byte_in;
      if (d != 0) begin
        slot = lane * LaneSlots + ptr_q[lane] % LaneSlots;
        data = ring_mem[slot];
        ring_mem[slot] = item.byte_in;
        nxt = ptr_q[lane] + 1;
        ptr_q[lane] = (nxt >= d) ? '0 : DelayBits'(nxt);
      end
      maxd = 0;
      for (int unsigned k = 0; k < n; k++) begin
        if (delay_of(k) > maxd) maxd = delay_of(k);
      end
      pos_q = (lane + 1 >= n) ? 0 : lane + 1;
      if (frames_q > maxd) begin
        r.byte_out      = data;
        r.lane          = LaneBits'(lane);
        r.last_of_frame = (lane + 1 == n);
        delayed_bytes_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_cnt_q = LaneCntBits'(LaneCntReset);
      foreach (delay_q[k]) delay_q[k] = '0;
      foreach (ptr_q[k]) ptr_q[k] = '0;
      foreach (ring_mem[k]) ring_mem[k] = '0;
      pos_q = 0;
      frames_q = 0;
      delayed_bytes_due.delete();
      pending_o = 0;
      errors_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[PaddrBits-1:3]))
          REG_LANE_COUNT: lane_cnt_q = pwdata[LaneCntBits-1:0];
          REG_DELAYS_0:   delay_q[0] = pwdata[DelayRegBits-1:0];
          REG_DELAYS_1:   delay_q[1] = pwdata[DelayRegBits-1:0];
          REG_DELAYS_2:   delay_q[2] = pwdata[DelayRegBits-1:0];
          REG_DELAYS_3:   delay_q[3] = pwdata[DelayRegBits-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (delayed_bytes_due.size() == 0) begin
          if (errors_o < 10) begin
            $display("unexpected item: byte %02h lane %0d last %0b", out_item_i.byte_out,
                     out_item_i.lane, out_item_i.last_of_frame);
          end
          errors_o++;
        end else begin
          want = delayed_bytes_due.pop_front();
          if (want.byte_out !== out_item_i.byte_out || want.lane !== out_item_i.lane ||
              want.last_of_frame !== out_item_i.last_of_frame) begin
            if (errors_o < 10) begin
              $display("mismatch: expected byte %02h lane %0d last %0b, %s %02h lane %0d last %0b",
                       want.byte_out, want.lane, want.last_of_frame, "got byte",
                       out_item_i.byte_out, out_item_i.lane, out_item_i.last_of_frame);
            end
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) run_delay_bank(in_item_i);
      pending_o = delayed_bytes_due.size();
    end
  end

endmodule

// ----- tb/multi_lane_byte_delay_bank_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_lane_byte_delay_bank_tb
// Drives byte and flush items into the delay bank through a series of lane
// count and delay settings, each applied while the bank is idle. Most
// settings start from a flush; some only shorten delays and lanes of a bank
// already in steady flow. Both channels idle and stall at random. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module multi_lane_byte_delay_bank_tb;
  import mlbdb_pkg::*;

  localparam int unsigned ItemTarget = 1800;
  localparam int unsigned SettleWait = 8;
  localparam int unsigned MaxDelay   = (1 << DelayBits) - 1;
  localparam int unsigned MaxLaneCnt = (1 << LaneCntBits) - 1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_item_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrBits-1:0] paddr;
  logic [DataBits-1:0]  pwdata;
  logic [DataBits-1:0]  prdata;
  logic                 pready;
  int unsigned          outstanding;
  int unsigned          mismatches;

  logic [LaneCntBits-1:0]  lane_cnt_plan;
  logic [DelayRegBits-1:0] delay_plan [DelayRegs];
  int unsigned             lane_at;
  int unsigned             frames_at;
  int unsigned             items_sent;
  int unsigned             flushes_sent;
  int unsigned             bytes_received;
  int unsigned             settings;
  int unsigned             shortened;
  bit                      quiet;

  multi_lane_byte_delay_bank dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  multi_lane_byte_delay_bank_checker bank_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_i (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending_o  (outstanding),
    .errors_o   (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("multi_lane_byte_delay_bank verification failed");
    $finish;
  end

  function automatic int unsigned active_lanes(input logic [LaneCntBits-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > Lanes) return Lanes;
    return 32'(cnt);
  endfunction

  function automatic int unsigned delay_at(input int unsigned lane);
    logic [DelayRegBits-1:0] r;
    r = delay_plan[lane / DelaysPerReg];
    return 32'(r[DelayBits*(lane % DelaysPerReg) +: DelayBits]);
  endfunction

  function automatic void set_delay(input int unsigned lane, input int unsigned d);
    delay_plan[lane / DelaysPerReg][DelayBits*(lane % DelaysPerReg) +: DelayBits] = DelayBits'(d);
  endfunction

  function automatic int unsigned longest_delay();
    int unsigned m;
    m = 0;
    for (int unsigned k = 0; k < active_lanes(lane_cnt_plan); k++) begin
      if (delay_at(k) > m) m = delay_at(k);
    end
    return m;
  endfunction

  task automatic send_item(input cmd_e c, input logic [7:0] b);
    in_item_t    it;
    int unsigned gap, n, lane;
    gap = quiet ? 0 : $urandom_range(0, 8);
    it.command = c;
    it.byte_in = b;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    n = active_lanes(lane_cnt_plan);
    if (c == CMD_FLUSH) begin
      lane_at = 0;
      frames_at = 0;
      flushes_sent++;
    end else begin
      lane = (lane_at >= n) ? 0 : lane_at;
      if (lane == 0 && frames_at < FramesSat) frames_at++;
      lane_at = (lane + 1 >= n) ? 0 : lane + 1;
    end
    items_sent++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataBits-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_plan();
    write_reg(REG_LANE_COUNT, DataBits'(lane_cnt_plan));
    write_reg(REG_DELAYS_0, DataBits'(delay_plan[0]));
    write_reg(REG_DELAYS_1, DataBits'(delay_plan[1]));
    write_reg(REG_DELAYS_2, DataBits'(delay_plan[2]));
    write_reg(REG_DELAYS_3, DataBits'(delay_plan[3]));
  endtask

  // hold the sender until every delayed byte is out and the pipeline is empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic plan_fresh(input int unsigned style, input bit all_max);
    int unsigned d;
    case (style)
      0: lane_cnt_plan = LaneCntBits'(Lanes);
      1: lane_cnt_plan = LaneCntBits'($urandom_range(0, 2));
      2: lane_cnt_plan = LaneCntBits'($urandom_range(Lanes + 1, MaxLaneCnt));
      default: begin
        lane_cnt_plan = ($urandom_range(0, 3) == 0) ? LaneCntBits'($urandom_range(9, Lanes))
                                                    : LaneCntBits'($urandom_range(1, 8));
      end
    endcase
    for (int unsigned lane = 0; lane < Lanes; lane++) begin
      case (style)
        0: d = $urandom_range(0, 3);
        1: d = all_max ? MaxDelay : $urandom_range(64, MaxDelay);
        2: d = $urandom_range(0, 2);
        default: d = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      endcase
      set_delay(lane, d);
    end
  endtask

  // shorten only: every slot the bank can reach was written in steady flow
  task automatic plan_shorter();
    lane_cnt_plan = LaneCntBits'($urandom_range(0, active_lanes(lane_cnt_plan)));
    for (int unsigned lane = 0; lane < Lanes; lane++) begin
      set_delay(lane, $urandom_range(0, delay_at(lane)));
    end
  endtask

  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 8);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      bytes_received++;
    end
  end

  initial begin
    int unsigned need, style, pick;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    items_sent     = 0;
    flushes_sent   = 0;
    bytes_received = 0;
    settings       = 0;
    shortened      = 0;
    quiet          = 1'b0;
    lane_at        = 0;
    frames_at      = 0;
    lane_cnt_plan  = LaneCntBits'(LaneCntReset);
    foreach (delay_plan[k]) delay_plan[k] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(CMD_PUSH, 8'h00);
    send_item(CMD_PUSH, 8'hFF);
    send_item(CMD_PUSH, 8'h55);
    send_item(CMD_PUSH, 8'hAA);
    send_item(CMD_FLUSH, 8'hFF);
    send_item(CMD_PUSH, 8'h01);
    send_item(CMD_PUSH, 8'h80);
    send_item(CMD_PUSH, 8'h7F);
    settle();
    lane_cnt_plan = '0;
    set_delay(0, 2);
    apply_plan();
    send_item(CMD_FLUSH, 8'h00);
    for (int k = 0; k < 6; k++) send_item(CMD_PUSH, 8'(8'hF0 + k));

    while (items_sent < ItemTarget) begin
      settle();
      if (settings > 2 && frames_at > longest_delay() && $urandom_range(0, 2) == 0) begin
        plan_shorter();
        apply_plan();
        shortened++;
      end else begin
        if (settings < 3) begin
          style = settings;
        end else begin
          pick = $urandom_range(0, 11);
          style = (pick == 0) ? 1 : (pick == 1) ? 0 : (pick == 2) ? 2 : 3;
        end
        plan_fresh(style, settings == 1);
        apply_plan();
        send_item(CMD_FLUSH, 8'($urandom_range(0, 255)));
      end
      settings++;
      quiet = ($urandom_range(0, 4) == 0);
      need = (longest_delay() + 1) * active_lanes(lane_cnt_plan) + $urandom_range(16, 120);
      repeat (need) begin
        send_item(($urandom_range(0, 49) == 0) ? CMD_FLUSH : CMD_PUSH,
                  8'($urandom_range(0, 255)));
      end
    end

    settle();
    $display("sent %0d items (%0d flushes) across %0d register settings, %0d of them shortened",
             items_sent, flushes_sent, settings, shortened);
    $display("received %0d delayed bytes under random sender gaps and receiver stalls",
             bytes_received);
    if (mismatches == 0) begin
      $display("multi_lane_byte_delay_bank verification clean");
    end else begin
      $display("multi_lane_byte_delay_bank verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mlbdb_pkg.sv
src/multi_lane_byte_delay_bank.sv
tb/multi_lane_byte_delay_bank_checker.sv
tb/multi_lane_byte_delay_bank_tb.sv
